// ===== rtl/qpu_pkg.sv =====
// Shared types and constants of the quaternion product unit.
package qpu_pkg;

  localparam int OP_W  = 3;
  localparam int PAT_W = 2;

  localparam logic [OP_W-1:0] OP_MUL     = 3'd0;
  localparam logic [OP_W-1:0] OP_CONJ_A  = 3'd1;
  localparam logic [OP_W-1:0] OP_CONJ_B  = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_FWD = 3'd3;
  localparam logic [OP_W-1:0] OP_ROT_BWD = 3'd4;

  // product forms: x*y, conj(x)*y, x*conj(y)
  localparam logic [PAT_W-1:0] PAT_XY   = 2'd0;
  localparam logic [PAT_W-1:0] PAT_CX_Y = 2'd1;
  localparam logic [PAT_W-1:0] PAT_X_CY = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [PAT_W-1:0] pat;
  } qpu_ctl_t;

  // Term t of component r is x[r^t]*y[t]; a set bit t means it is subtracted.
  localparam logic [3:0] NEG_MASK [3][4] = '{
    '{4'b1110, 4'b0100, 4'b1000, 4'b0010},
    '{4'b0000, 4'b1001, 4'b0011, 4'b0101},
    '{4'b0000, 4'b1010, 4'b0110, 4'b1100}
  };

  function automatic logic [3:0] neg_mask(input logic [PAT_W-1:0] pat,
                                          input logic [1:0] comp);
    logic [3:0] m;
    m = 4'b0000;
    if (pat == PAT_XY || pat == PAT_CX_Y || pat == PAT_X_CY) begin
      m = NEG_MASK[pat][comp];
    end
    return m;
  endfunction

endpackage

// ===== rtl/qpu_mul_pipe.sv =====
// Four-stage quaternion product pipeline: multiply, round/clamp, add, saturate.
module qpu_mul_pipe #(
  parameter int W    = 32,
  parameter int F    = 29,
  parameter int SB_W = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv_i,
  input  qpu_pkg::qpu_ctl_t       ctl_i,
  input  logic signed [W-1:0]     x_i [4],
  input  logic signed [W-1:0]     y_i [4],
  input  logic [SB_W-1:0]         sb_i,
  output logic                    vld_o,
  output logic signed [W-1:0]     res_o [4],
  output logic [3:0]              sat_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int PRW = 2*W + 1;
  localparam int RW  = PRW - F;
  localparam int PW  = (RW > 62) ? RW : 62;
  localparam int SW  = PW + 2;

  localparam logic signed [PRW-1:0] HALF = {{(PRW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [PW-1:0]  PLIM = {{(PW-61){1'b0}}, 1'b1, 60'b0};
  localparam logic signed [PW-1:0]  NLIM = -PLIM;
  localparam logic signed [SW-1:0]  SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0]  SMIN = ~SMAX;

  // stage A: raw products
  logic signed [2*W-1:0]   prod_nxt [4][4];
  logic signed [2*W-1:0]   prod_r   [4][4];
  logic                    vld_a_r;
  logic [qpu_pkg::PAT_W-1:0] pat_a_r;
  logic [SB_W-1:0]         sb_a_r;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int t = 0; t < 4; t++) begin
        prod_nxt[r][t] = x_i[2'(r ^ t)] * y_i[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv_i) begin
      vld_a_r <= ctl_i.vld;
    end
    if (adv_i) begin
      prod_r  <= prod_nxt;
      pat_a_r <= ctl_i.pat;
      sb_a_r  <= sb_i;
    end
  end

  // stage B: round half up, clamp to +-2^60
  logic signed [PW-1:0]    rnd_nxt [4][4];
  logic signed [PW-1:0]    rnd_r   [4][4];
  logic                    vld_b_r;
  logic [qpu_pkg::PAT_W-1:0] pat_b_r;
  logic [SB_W-1:0]         sb_b_r;

  always_comb begin
    logic signed [PRW-1:0] pe;
    logic signed [RW-1:0]  sh;
    logic signed [PW-1:0]  ext;
    for (int r = 0; r < 4; r++) begin
      for (int t = 0; t < 4; t++) begin
        pe  = {prod_r[r][t][2*W-1], prod_r[r][t]} + HALF;
        sh  = RW'(pe >>> F);
        ext = PW'(sh);
        if (ext > PLIM) begin
          rnd_nxt[r][t] = PLIM;
        end else if (ext < NLIM) begin
          rnd_nxt[r][t] = NLIM;
        end else begin
          rnd_nxt[r][t] = ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (adv_i) begin
      vld_b_r <= vld_a_r;
    end
    if (adv_i) begin
      rnd_r   <= rnd_nxt;
      pat_b_r <= pat_a_r;
      sb_b_r  <= sb_a_r;
    end
  end

  // stage C: signed sum of four terms
  logic signed [SW-1:0] sum_nxt [4];
  logic signed [SW-1:0] sum_r   [4];
  logic                 vld_c_r;
  logic [SB_W-1:0]      sb_c_r;

  always_comb begin
    logic [3:0] m;
    for (int r = 0; r < 4; r++) begin
      m = qpu_pkg::neg_mask(pat_b_r, 2'(r));
      sum_nxt[r] = '0;
      for (int t = 0; t < 4; t++) begin
        if (m[t]) begin
          sum_nxt[r] = sum_nxt[r] - SW'(rnd_r[r][t]);
        end else begin
          sum_nxt[r] = sum_nxt[r] + SW'(rnd_r[r][t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (adv_i) begin
      vld_c_r <= vld_b_r;
    end
    if (adv_i) begin
      sum_r  <= sum_nxt;
      sb_c_r <= sb_b_r;
    end
  end

  // stage D: saturate to component range
  logic signed [W-1:0] res_nxt [4];
  logic signed [W-1:0] res_r   [4];
  logic [3:0]          sat_nxt;
  logic [3:0]          sat_r;
  logic                vld_d_r;
  logic [SB_W-1:0]     sb_d_r;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (sum_r[r] > SMAX) begin
        res_nxt[r] = SMAX[W-1:0];
        sat_nxt[r] = 1'b1;
      end else if (sum_r[r] < SMIN) begin
        res_nxt[r] = SMIN[W-1:0];
        sat_nxt[r] = 1'b1;
      end else begin
        res_nxt[r] = sum_r[r][W-1:0];
        sat_nxt[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (adv_i) begin
      vld_d_r <= vld_c_r;
    end
    if (adv_i) begin
      res_r  <= res_nxt;
      sat_r  <= sat_nxt;
      sb_d_r <= sb_c_r;
    end
  end

  assign vld_o = vld_d_r;
  assign res_o = res_r;
  assign sat_o = sat_r;
  assign sb_o  = sb_d_r;

endmodule

// ===== rtl/quaternion_product_unit_core.sv =====
// Top level of the pipelined fixed-point quaternion product unit.
//
// Input channel in_*: one word per item holds the operation code and the two
// quaternions a and b. Output channel out_*: one word per item with the result
// quaternion and an overflow flag. Operations: a*b, conj(a)*b, a*conj(b), and
// rotation of the vector part of b as a v conj(a) or conj(a) v a (scalar part
// of the result is zero). Undefined codes give an all-zero word.
//
// Two four-stage product pipelines in series (multiply, round and clamp,
// four-term add, saturate) feed the output register. A new word is taken
// every cycle unless out_tready stalls; the rotation's second product runs
// in the second pipeline, so both product forms sustain one word per cycle.
//
// Reset clears every valid bit; the pipeline comes up empty with out_tvalid
// low. When the receiver holds out_tready low with a word waiting, the whole
// pipeline freezes and in_tready drops in the same cycle; nothing is lost or
// repeated, and flow resumes as soon as out_tready returns.
module quaternion_product_unit_core #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 29
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // operation, a_scalar, a_x, a_y, a_z, b_scalar, b_x, b_y, b_z (lowest first)
  input  logic [((qpu_pkg::OP_W + 8*COMP_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // r_scalar, r_x, r_y, r_z, overflow (lowest first)
  output logic [((4*COMP_WIDTH + 1 + 7) / 8) * 8 - 1:0]             out_tdata
);

  localparam int W     = COMP_WIDTH;
  localparam int OPW   = qpu_pkg::OP_W;
  localparam int IN_W  = ((OPW + 8*COMP_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((4*COMP_WIDTH + 1 + 7) / 8) * 8;
  localparam int SB1_W = OPW + 4*W;
  localparam int SB2_W = OPW + 4 + 4*W;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input unpack
  logic [OPW-1:0]      op_in;
  logic signed [W-1:0] a_in  [4];
  logic signed [W-1:0] b_in  [4];
  logic signed [W-1:0] y1    [4];
  logic                rot_in;
  qpu_pkg::qpu_ctl_t   ctl1;
  logic [SB1_W-1:0]    sb1_in;

  always_comb begin
    op_in  = in_tdata[OPW-1:0];
    rot_in = (op_in == qpu_pkg::OP_ROT_FWD) || (op_in == qpu_pkg::OP_ROT_BWD);
    for (int i = 0; i < 4; i++) begin
      a_in[i] = in_tdata[OPW + i*W +: W];
      b_in[i] = in_tdata[OPW + (4+i)*W +: W];
      y1[i]   = b_in[i];
    end
    if (rot_in) begin
      y1[0] = '0;
    end
    ctl1.vld = in_tvalid;
    unique case (op_in) inside
      qpu_pkg::OP_MUL, qpu_pkg::OP_ROT_FWD:    ctl1.pat = qpu_pkg::PAT_XY;
      qpu_pkg::OP_CONJ_A, qpu_pkg::OP_ROT_BWD: ctl1.pat = qpu_pkg::PAT_CX_Y;
      qpu_pkg::OP_CONJ_B:                      ctl1.pat = qpu_pkg::PAT_X_CY;
      default:                                 ctl1.pat = qpu_pkg::PAT_XY;
    endcase
    sb1_in = {op_in, a_in[3], a_in[2], a_in[1], a_in[0]};
  end

  // first product
  logic                u1_vld;
  logic signed [W-1:0] t_q   [4];
  logic [3:0]          sat1;
  logic [SB1_W-1:0]    sb1_out;

  qpu_mul_pipe #(.W(W), .F(FRAC_BITS), .SB_W(SB1_W)) u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .adv_i (adv),
    .ctl_i (ctl1),
    .x_i   (a_in),
    .y_i   (y1),
    .sb_i  (sb1_in),
    .vld_o (u1_vld),
    .res_o (t_q),
    .sat_o (sat1),
    .sb_o  (sb1_out)
  );

  // second product (rotation only; others ride along in the side band)
  logic [OPW-1:0]      op_mid;
  logic signed [W-1:0] a_mid [4];
  qpu_pkg::qpu_ctl_t   ctl2;
  logic [SB2_W-1:0]    sb2_in;

  always_comb begin
    op_mid = sb1_out[4*W +: OPW];
    for (int i = 0; i < 4; i++) begin
      a_mid[i] = sb1_out[i*W +: W];
    end
    ctl2.vld = u1_vld;
    ctl2.pat = (op_mid == qpu_pkg::OP_ROT_FWD) ? qpu_pkg::PAT_X_CY : qpu_pkg::PAT_XY;
    sb2_in   = {op_mid, sat1, t_q[3], t_q[2], t_q[1], t_q[0]};
  end

  logic                u2_vld;
  logic signed [W-1:0] u_q   [4];
  logic [3:0]          sat2;
  logic [SB2_W-1:0]    sb2_out;

  qpu_mul_pipe #(.W(W), .F(FRAC_BITS), .SB_W(SB2_W)) u_mul2 (
    .clk   (clk),
    .rst_n (rst_n),
    .adv_i (adv),
    .ctl_i (ctl2),
    .x_i   (t_q),
    .y_i   (a_mid),
    .sb_i  (sb2_in),
    .vld_o (u2_vld),
    .res_o (u_q),
    .sat_o (sat2),
    .sb_o  (sb2_out)
  );

  // result select and output register
  logic [OPW-1:0]      op_fin;
  logic [3:0]          sat_fin1;
  logic signed [W-1:0] t_fin [4];
  logic signed [W-1:0] r_sel [4];
  logic                ov_sel;
  logic [OUT_W-1:0]    out_tdata_nxt;
  logic [OUT_W-1:0]    out_tdata_r;
  logic                out_tvalid_r;

  always_comb begin
    op_fin   = sb2_out[4*W + 4 +: OPW];
    sat_fin1 = sb2_out[4*W +: 4];
    for (int i = 0; i < 4; i++) begin
      t_fin[i] = sb2_out[i*W +: W];
      r_sel[i] = '0;
    end
    ov_sel = 1'b0;
    unique case (op_fin) inside
      qpu_pkg::OP_MUL, qpu_pkg::OP_CONJ_A, qpu_pkg::OP_CONJ_B: begin
        r_sel  = t_fin;
        ov_sel = |sat_fin1;
      end
      qpu_pkg::OP_ROT_FWD, qpu_pkg::OP_ROT_BWD: begin
        r_sel[1] = u_q[1];
        r_sel[2] = u_q[2];
        r_sel[3] = u_q[3];
        ov_sel   = (|sat_fin1) || (|sat2[3:1]);
      end
      default: begin
        ov_sel = 1'b0;
      end
    endcase
    out_tdata_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      out_tdata_nxt[i*W +: W] = r_sel[i];
    end
    out_tdata_nxt[4*W] = ov_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= u2_vld;
    end
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_rot_scalar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && u2_vld && (op_fin == qpu_pkg::OP_ROT_FWD || op_fin == qpu_pkg::OP_ROT_BWD))
    |=> (out_tvalid && out_tdata[W-1:0] == '0))
    else $error("rotation result with nonzero scalar part");

  a_bad_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && u2_vld && !(op_fin == qpu_pkg::OP_MUL || op_fin == qpu_pkg::OP_CONJ_A ||
      op_fin == qpu_pkg::OP_CONJ_B || op_fin == qpu_pkg::OP_ROT_FWD ||
      op_fin == qpu_pkg::OP_ROT_BWD))
    |=> (out_tvalid && out_tdata == '0))
    else $error("undefined operation gave a nonzero word");

  a_pipe_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && u2_vld) |=> u2_vld)
    else $error("item dropped from the pipeline during a stall");

endmodule

// ===== dv/tb_quaternion_product_unit_core.sv =====
// Self-checking stream testbench of the fixed-point quaternion product unit.
`timescale 1ns / 1ps

module tb_quaternion_product_unit_core;

  localparam int OPW      = qpu_pkg::OP_W;
  localparam int CW       = 32;
  localparam int FB       = 29;
  localparam int IN_W     = ((OPW + 8 * CW + 7) / 8) * 8;
  localparam int OUT_W    = ((4 * CW + 1 + 7) / 8) * 8;
  localparam int IDLE_MAX = 5000;
  localparam int TAIL     = 20;
  localparam int N_RAND   = 1000;

  localparam int ONE = 1 << FB;
  localparam int TIE = 1 << (FB - 1);
  localparam int C45 = 379625062;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [IN_W-OPW-8*CW-1:0] pad;
    logic signed [CW-1:0] b_z, b_y, b_x, b_s, a_z, a_y, a_x, a_s;
    logic [OPW-1:0] op;
  } quat_in_t;

  typedef struct packed {
    logic [OUT_W-4*CW-2:0] pad;
    logic ovf;
    logic signed [CW-1:0] r_z, r_y, r_x, r_s;
  } quat_out_t;

  class quat_result_board;
    // bit t of nibble (pattern*4 + component) set: term x[comp^t]*y[t] is subtracted
    localparam logic [47:0] SUB_SIGNS =
      48'b1100_0110_1010_0000_0101_0011_1001_0000_0010_1000_0100_1110;

    quat_out_t pending[$];
    int errors;
    int checked;
    int ovf_seen;
    int op_count[8];

    function longint mul_round(longint x, longint y);
      longint p;
      longint lim;
      p   = (x * y + (longint'(1) <<< (FB - 1))) >>> FB;
      lim = longint'(1) <<< 60;
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      return p;
    endfunction

    function longint clip(longint s, inout bit ov);
      longint hi;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      if (s > hi) begin
        ov = 1'b1;
        return hi;
      end
      if (s < -hi - 1) begin
        ov = 1'b1;
        return -hi - 1;
      end
      return s;
    endfunction

    function longint term_sum(logic [qpu_pkg::PAT_W-1:0] pat, int comp,
                              longint x[4], longint y[4], inout bit ov);
      longint sum;
      longint p;
      sum = 0;
      for (int t = 0; t < 4; t++) begin
        p = mul_round(x[comp ^ t], y[t]);
        if (SUB_SIGNS[(int'(pat) * 4 + comp) * 4 + t]) sum -= p;
        else sum += p;
      end
      return clip(sum, ov);
    endfunction

    function quat_out_t predict_product(quat_in_t w);
      longint a[4], b[4], v[4], t[4], r[4];
      bit ov;
      quat_out_t res;
      a[0] = w.a_s; a[1] = w.a_x; a[2] = w.a_y; a[3] = w.a_z;
      b[0] = w.b_s; b[1] = w.b_x; b[2] = w.b_y; b[3] = w.b_z;
      ov = 1'b0;
      for (int i = 0; i < 4; i++) r[i] = 0;
      case (w.op) inside
        qpu_pkg::OP_MUL: begin
          for (int i = 0; i < 4; i++) r[i] = term_sum(qpu_pkg::PAT_XY, i, a, b, ov);
        end
        qpu_pkg::OP_CONJ_A: begin
          for (int i = 0; i < 4; i++) r[i] = term_sum(qpu_pkg::PAT_CX_Y, i, a, b, ov);
        end
        qpu_pkg::OP_CONJ_B: begin
          for (int i = 0; i < 4; i++) r[i] = term_sum(qpu_pkg::PAT_X_CY, i, a, b, ov);
        end
        qpu_pkg::OP_ROT_FWD, qpu_pkg::OP_ROT_BWD: begin
          v = b;
          v[0] = 0;
          for (int i = 0; i < 4; i++)
            t[i] = term_sum((w.op == qpu_pkg::OP_ROT_FWD) ? qpu_pkg::PAT_XY
                            : qpu_pkg::PAT_CX_Y, i, a, v, ov);
          for (int i = 1; i < 4; i++)
            r[i] = term_sum((w.op == qpu_pkg::OP_ROT_FWD) ? qpu_pkg::PAT_X_CY
                            : qpu_pkg::PAT_XY, i, t, a, ov);
        end
        default: ;
      endcase
      res     = '0;
      res.r_s = r[0][CW-1:0];
      res.r_x = r[1][CW-1:0];
      res.r_y = r[2][CW-1:0];
      res.r_z = r[3][CW-1:0];
      res.ovf = ov;
      return res;
    endfunction

    function void note_operands(quat_in_t w);
      pending.push_back(predict_product(w));
      op_count[w.op]++;
    endfunction

    function void cmp_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_product(quat_out_t got);
      quat_out_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.ovf) ovf_seen++;
      cmp_field("r_scalar", want.r_s, got.r_s);
      cmp_field("r_x", want.r_x, got.r_x);
      cmp_field("r_y", want.r_y, got.r_y);
      cmp_field("r_z", want.r_z, got.r_z);
      cmp_field("overflow", want.ovf, got.ovf);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  quat_result_board board = new;
  int burst_left;
  int idle_cycles;
  int rx_mode;
  int rx_left;
  int rx_phase;

  quaternion_product_unit_core #(
    .COMP_WIDTH(CW),
    .FRAC_BITS (FB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_operands(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_product(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_MAX);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: free flow, coin flips, long stalls, or a fixed 3-of-4 pattern
  initial begin
    out_tready <= 1'b0;
    rx_mode  = 0;
    rx_left  = 0;
    rx_phase = 0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 15) == 0);
        default: out_tready <= (rx_phase % 4 != 0);
      endcase
    end
  end

  function automatic quat_in_t mk(logic [OPW-1:0] op,
                                  logic signed [CW-1:0] as, ax, ay, az, bs, bx, by, bz);
    quat_in_t w;
    w = '0;
    w.op = op;
    w.a_s = as; w.a_x = ax; w.a_y = ay; w.a_z = az;
    w.b_s = bs; w.b_x = bx; w.b_y = by; w.b_z = bz;
    return w;
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $urandom_range(0, 2 * ONE) - ONE;
      8: begin
        case ($urandom_range(0, 4))
          0:       return MAXV;
          1:       return MINV;
          2:       return 0;
          3:       return 1;
          default: return -1;
        endcase
      end
      default: return ($urandom_range(0, 7) - 4) * TIE;
    endcase
  endfunction

  task automatic send_word(input quat_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [OPW-1:0] code;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(mk(qpu_pkg::OP_MUL, ONE, 0, 0, 0, ONE, ONE, -ONE, ONE));
    send_word(mk(qpu_pkg::OP_MUL, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_word(mk(qpu_pkg::OP_MUL, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    send_word(mk(qpu_pkg::OP_MUL, MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV, MAXV));
    send_word(mk(qpu_pkg::OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(qpu_pkg::OP_MUL, 1, 1, 1, 1, TIE, TIE, TIE, TIE));
    send_word(mk(qpu_pkg::OP_MUL, -1, -1, -1, -1, TIE, TIE, TIE, TIE));
    send_word(mk(qpu_pkg::OP_CONJ_A, ONE, ONE, ONE, ONE, ONE, -ONE, ONE, -ONE));
    send_word(mk(qpu_pkg::OP_CONJ_A, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV));
    send_word(mk(qpu_pkg::OP_CONJ_A, 1, -1, 1, -1, TIE, TIE, -TIE, -TIE));
    send_word(mk(qpu_pkg::OP_CONJ_B, ONE, -ONE, ONE, ONE, ONE, ONE, ONE, -ONE));
    send_word(mk(qpu_pkg::OP_CONJ_B, MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV, MAXV));
    send_word(mk(qpu_pkg::OP_CONJ_B, -1, 1, -1, 1, -TIE, TIE, TIE, -TIE));
    send_word(mk(qpu_pkg::OP_ROT_FWD, C45, 0, 0, C45, MAXV, ONE, 0, 0));
    send_word(mk(qpu_pkg::OP_ROT_FWD, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV));
    send_word(mk(qpu_pkg::OP_ROT_FWD, MINV, MINV, MINV, MINV, 0, MINV, MINV, MINV));
    send_word(mk(qpu_pkg::OP_ROT_FWD, 1, -1, 1, 1, 0, TIE, -TIE, TIE));
    send_word(mk(qpu_pkg::OP_ROT_BWD, C45, 0, 0, C45, MINV, ONE, 0, 0));
    send_word(mk(qpu_pkg::OP_ROT_BWD, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV));
    send_word(mk(qpu_pkg::OP_ROT_BWD, MINV, MINV, MINV, MINV, 0, MAXV, MAXV, MAXV));
    send_word(mk(qpu_pkg::OP_ROT_BWD, -1, 1, 1, -1, ONE, -TIE, TIE, TIE));
    code = qpu_pkg::OP_ROT_BWD;
    repeat ((1 << OPW) - 1 - qpu_pkg::OP_ROT_BWD) begin
      code++;
      send_word(mk(code, MAXV, MINV, ONE, -ONE, MAXV, MINV, ONE, -ONE));
    end

    repeat (N_RAND) begin
      if ($urandom_range(0, 15) == 0) begin
        code = OPW'($urandom_range(qpu_pkg::OP_ROT_BWD + 1, (1 << OPW) - 1));
      end else begin
        code = OPW'($urandom_range(qpu_pkg::OP_MUL, qpu_pkg::OP_ROT_BWD));
      end
      send_word(mk(code, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    end
    in_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d words: %0d a*b, %0d conj(a)*b, %0d a*conj(b),",
             board.op_count.sum(), board.op_count[qpu_pkg::OP_MUL],
             board.op_count[qpu_pkg::OP_CONJ_A], board.op_count[qpu_pkg::OP_CONJ_B]);
    $display("  %0d a v conj(a), %0d conj(a) v a; %0d results checked, %0d saturated,",
             board.op_count[qpu_pkg::OP_ROT_FWD], board.op_count[qpu_pkg::OP_ROT_BWD],
             board.checked, board.ovf_seen);
    $display("  %0d undefined codes, under random back-pressure",
             board.op_count.sum() - board.op_count[qpu_pkg::OP_MUL]
             - board.op_count[qpu_pkg::OP_CONJ_A] - board.op_count[qpu_pkg::OP_CONJ_B]
             - board.op_count[qpu_pkg::OP_ROT_FWD] - board.op_count[qpu_pkg::OP_ROT_BWD]);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
